[hw/rtl/lorf_pkg.sv]
// ============================================================================
// Log-odds risk filter package
// Shared register indexes, risk state codes, fixed-point limits and the
// elaboration-time sigmoid generator used to build the probability table.
// ============================================================================
`default_nettype none

package lorf_pkg;

    // Widths of the fixed fields.
    localparam int LO_W    = 16;  // Q5.10 log-odds
    localparam int PROB_W  = 16;  // Q0.16 probability
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd7;

    // Register reset values.
    localparam logic signed [LO_W-1:0] RST_PRIOR   = 16'sd0;
    localparam logic signed [LO_W-1:0] RST_HIT     = 16'sd2048;
    localparam logic signed [LO_W-1:0] RST_MISS    = -16'sd2048;
    localparam logic [LO_W-1:0]        RST_DECAY   = 16'd29491;
    localparam logic signed [LO_W-1:0] RST_SUSPECT = 16'sd0;
    localparam logic signed [LO_W-1:0] RST_TRIGGER = 16'sd2048;
    localparam logic signed [LO_W-1:0] RST_RELEASE = -16'sd2048;
    localparam logic [7:0]             RST_CONFIRM = 8'd3;

    // Risk state codes.
    localparam logic [STATE_W-1:0] MODE_CLEAR     = 3'd0;
    localparam logic [STATE_W-1:0] MODE_SUSPECTED = 3'd1;
    localparam logic [STATE_W-1:0] MODE_CONFIRMED = 3'd2;
    localparam logic [STATE_W-1:0] MODE_RELEASING = 3'd3;
    localparam logic [STATE_W-1:0] MODE_FAULT     = 3'd4;

    // Log-odds clamp, +-20.0 in Q5.10. The full span 40960 is 5 * 2^13.
    localparam int LO_LIMIT      = 20480;
    localparam int LO_SPAN_SHIFT = 13;

    // floor(t / 5) = (t * 52429) >> 18, exact for t below 2^18.
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    // Restoring long division, used only while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-f/1024) in Q31 for f in [0, 1024], by a 21-term series.
    function automatic logic [63:0] exp_neg_frac(logic [10:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 32;
        sum  = term;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64(term * 64'(f), 64'(k) << 10);
            sum  = sum + term;
        end
        return udiv64(64'd1 << 63, sum);
    endfunction

    // exp(-a/1024) in Q31 for a in [0, 20480].
    function automatic logic [63:0] exp_neg(logic [14:0] a);
        logic [63:0] e1;
        logic [63:0] r;
        logic [4:0]  n;
        e1 = exp_neg_frac(11'd1024);
        r  = exp_neg_frac({1'b0, a[9:0]});
        n  = a[14:10];
        for (int j = 0; j < 32; j++) begin
            if (j < int'(n)) begin
                r = (r * e1) >> 31;
            end
        end
        return r;
    endfunction

    // Sigmoid of a Q5.10 point as unsigned Q0.16, saturated to all ones.
    function automatic logic [PROB_W-1:0] sigmoid_q16(int x);
        int          a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] p;
        a = (x < 0) ? -x : x;
        e = exp_neg(15'(a));
        d = Q31_ONE + e;
        if (x >= 0) begin
            p = udiv64((64'd1 << 47) + (d >> 1), d);
        end else begin
            p = udiv64((e << 16) + (d >> 1), d);
        end
        return (p > 64'd65535) ? 16'hFFFF : p[15:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lorf_frame_if.sv]
// ============================================================================
// Frame channel
// Valid/ready channel carrying one sensor frame: occupancy and validity.
// ============================================================================
`default_nettype none

interface lorf_frame_if;
    logic valid;
    logic ready;
    logic occupied;
    logic frame_valid;

    modport source (output valid, output occupied, output frame_valid, input ready);
    modport sink   (input valid, input occupied, input frame_valid, output ready);
endinterface

`default_nettype wire

[hw/rtl/lorf_risk_if.sv]
// ============================================================================
// Risk channel
// Valid/ready channel carrying one result: risk state and probability.
// ============================================================================
`default_nettype none

interface lorf_risk_if;
    logic                          valid;
    logic                          ready;
    logic [lorf_pkg::STATE_W-1:0]  risk_state;
    logic [lorf_pkg::PROB_W-1:0]   risk_probability;

    modport source (output valid, output risk_state, output risk_probability, input ready);
    modport sink   (input valid, input risk_state, input risk_probability, output ready);
endinterface

`default_nettype wire

[hw/rtl/log_odds_risk_filter_top.sv]
// ============================================================================
// Log-odds risk filter
// Binary Bayes occupancy filter in Q5.10 log-odds with a five-state
// hysteresis machine and a sigmoid probability table.
// ============================================================================
// Usage:
//   Frames enter on i_frame (valid/ready); every frame transfer yields exactly
//   one result on o_risk (valid/ready), in order.
//   The pipeline has five register stages: frame capture, belief and state
//   update, table scaling, index division, table read. One frame is accepted
//   every clock while the receiver keeps ready high; the belief and state
//   registers close their feedback loop within a single stage.
//   When the receiver stalls, the stages fill one by one; i_frame.ready drops
//   only when every stage holds a frame, so up to five frames are in flight.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data. The user must write them only while no frame is in flight;
//   the block itself does not enforce this.
//   Synchronous reset (i_rst_n low) empties the pipeline, loads the register
//   defaults, sets the state to clear, the belief to zero and both run
//   counters to zero. The sigmoid table is constant and needs no fill.
// ============================================================================
`default_nettype none

module log_odds_risk_filter_top #(
    parameter int RELEASE_FRAMES  = 3,
    parameter int COUNT_BITS      = 8,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lorf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lorf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lorf_frame_if.sink                               i_frame,
    lorf_risk_if.source                              o_risk
);

    localparam int IDX_W   = $clog2(SIGMOID_ENTRIES);
    localparam int SCL_W   = lorf_pkg::LO_W + IDX_W + 1;
    localparam int T_W     = IDX_W + 3;
    localparam int DIVP_W  = T_W + 16;
    localparam int CNT_CMP = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Configuration registers.
    logic signed [15:0] r_prior;
    logic signed [15:0] r_hit;
    logic signed [15:0] r_miss;
    logic [15:0]        r_decay;
    logic signed [15:0] r_suspect;
    logic signed [15:0] r_trigger;
    logic signed [15:0] r_release;
    logic [7:0]         r_confirm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior   <= lorf_pkg::RST_PRIOR;
            r_hit     <= lorf_pkg::RST_HIT;
            r_miss    <= lorf_pkg::RST_MISS;
            r_decay   <= lorf_pkg::RST_DECAY;
            r_suspect <= lorf_pkg::RST_SUSPECT;
            r_trigger <= lorf_pkg::RST_TRIGGER;
            r_release <= lorf_pkg::RST_RELEASE;
            r_confirm <= lorf_pkg::RST_CONFIRM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lorf_pkg::REG_PRIOR:   r_prior   <= i_cfg_data;
                lorf_pkg::REG_HIT:     r_hit     <= i_cfg_data;
                lorf_pkg::REG_MISS:    r_miss    <= i_cfg_data;
                lorf_pkg::REG_DECAY:   r_decay   <= i_cfg_data;
                lorf_pkg::REG_SUSPECT: r_suspect <= i_cfg_data;
                lorf_pkg::REG_TRIGGER: r_trigger <= i_cfg_data;
                lorf_pkg::REG_RELEASE: r_release <= i_cfg_data;
                lorf_pkg::REG_CONFIRM: r_confirm <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and the ready chain from the output backwards.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4        = !r_v4 || o_risk.ready;
    assign w_rdy3        = !r_v3 || w_rdy4;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign i_frame.ready = !r_v0 || w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (i_frame.ready) r_v0 <= i_frame.valid;
            if (w_rdy1)        r_v1 <= r_v0;
            if (w_rdy2)        r_v2 <= r_v1;
            if (w_rdy3)        r_v3 <= r_v2;
            if (w_rdy4)        r_v4 <= r_v3;
        end
    end

    // Stage 0: frame capture.
    logic r_s0_occ;
    logic r_s0_fv;

    always_ff @(posedge i_clk) begin
        if (i_frame.ready) begin
            r_s0_occ <= i_frame.occupied;
            r_s0_fv  <= i_frame.frame_valid;
        end
    end

    // Stage 1: filter state. These registers also hold the stage 1 result.
    logic [lorf_pkg::STATE_W-1:0] r_mode, n_mode;
    logic signed [15:0]           r_belief, n_belief;
    logic [COUNT_BITS-1:0]        r_occ_run, n_occ_run;
    logic [COUNT_BITS-1:0]        r_rel_run, n_rel_run;

    // Decay toward the prior: prior + round(decay * (belief - prior) / 2^15) + step.
    logic signed [16:0] w_diff;
    logic signed [33:0] w_prod;
    logic signed [33:0] w_rnd;
    logic signed [18:0] w_scaled;
    logic signed [15:0] w_step;
    logic signed [20:0] w_sum;
    logic signed [15:0] w_new_belief;
    logic signed [15:0] w_prior_clamped;

    assign w_diff   = 17'(r_belief) - 17'(r_prior);
    assign w_prod   = $signed({1'b0, r_decay}) * w_diff;
    assign w_rnd    = w_prod + 34'sd16384;
    assign w_scaled = w_rnd[33:15];
    assign w_step   = r_s0_occ ? r_hit : r_miss;
    assign w_sum    = 21'(r_prior) + 21'(w_scaled) + 21'(w_step);

    always_comb begin
        if (w_sum > 21'(lorf_pkg::LO_LIMIT)) begin
            w_new_belief = 16'(lorf_pkg::LO_LIMIT);
        end else if (w_sum < -21'(lorf_pkg::LO_LIMIT)) begin
            w_new_belief = -16'(lorf_pkg::LO_LIMIT);
        end else begin
            w_new_belief = w_sum[15:0];
        end
    end

    always_comb begin
        if (r_prior > 16'(lorf_pkg::LO_LIMIT)) begin
            w_prior_clamped = 16'(lorf_pkg::LO_LIMIT);
        end else if (r_prior < -16'(lorf_pkg::LO_LIMIT)) begin
            w_prior_clamped = -16'(lorf_pkg::LO_LIMIT);
        end else begin
            w_prior_clamped = r_prior;
        end
    end

    // Run counters and thresholds on the new belief.
    logic [COUNT_BITS-1:0]        w_occ_next;
    logic [COUNT_BITS-1:0]        w_rel_inc;
    logic [lorf_pkg::STATE_W-1:0] w_mode_in;
    logic                         w_at_suspect;
    logic                         w_at_trigger;
    logic                         w_below_release;
    logic                         w_occ_enough;
    logic                         w_rel_done;

    assign w_occ_next      = !r_s0_occ ? '0 :
                             (r_occ_run == CNT_MAX) ? r_occ_run : r_occ_run + CNT_ONE;
    assign w_rel_inc       = (r_rel_run == CNT_MAX) ? r_rel_run : r_rel_run + CNT_ONE;
    assign w_mode_in       = (r_mode == lorf_pkg::MODE_FAULT) ? lorf_pkg::MODE_CLEAR : r_mode;
    assign w_at_suspect    = w_new_belief >= r_suspect;
    assign w_at_trigger    = w_new_belief >= r_trigger;
    assign w_below_release = w_new_belief < r_release;
    assign w_occ_enough    = CNT_CMP'(w_occ_next) >= CNT_CMP'(r_confirm);
    assign w_rel_done      = 32'(w_rel_inc) >= 32'(RELEASE_FRAMES);

    // Hysteresis machine.
    always_comb begin
        n_mode    = r_mode;
        n_belief  = r_belief;
        n_occ_run = r_occ_run;
        n_rel_run = r_rel_run;
        if (!r_s0_fv) begin
            n_mode    = lorf_pkg::MODE_FAULT;
            n_belief  = w_prior_clamped;
            n_occ_run = '0;
            n_rel_run = '0;
        end else begin
            n_belief  = w_new_belief;
            n_occ_run = w_occ_next;
            n_mode    = w_mode_in;
            unique case (w_mode_in)
                lorf_pkg::MODE_CLEAR: begin
                    if (w_at_suspect) n_mode = lorf_pkg::MODE_SUSPECTED;
                end
                lorf_pkg::MODE_SUSPECTED: begin
                    if (w_at_trigger && w_occ_enough) begin
                        n_mode = lorf_pkg::MODE_CONFIRMED;
                    end else if (w_below_release) begin
                        n_mode = lorf_pkg::MODE_CLEAR;
                    end
                end
                lorf_pkg::MODE_CONFIRMED: begin
                    if (w_below_release) begin
                        n_mode    = lorf_pkg::MODE_RELEASING;
                        n_rel_run = CNT_ONE;
                    end
                end
                lorf_pkg::MODE_RELEASING: begin
                    if (w_at_trigger) begin
                        n_mode    = lorf_pkg::MODE_CONFIRMED;
                        n_rel_run = '0;
                    end else if (w_below_release) begin
                        if (w_rel_done) begin
                            n_mode    = lorf_pkg::MODE_CLEAR;
                            n_rel_run = '0;
                        end else begin
                            n_rel_run = w_rel_inc;
                        end
                    end else begin
                        n_rel_run = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lorf_pkg::MODE_CLEAR;
            r_belief  <= '0;
            r_occ_run <= '0;
            r_rel_run <= '0;
        end else if (r_v0 && w_rdy1) begin
            r_mode    <= n_mode;
            r_belief  <= n_belief;
            r_occ_run <= n_occ_run;
            r_rel_run <= n_rel_run;
        end
    end

    // Stage 2: t = floor(((belief + 20480) * (N - 1) + 20480) / 2^13).
    logic [15:0]                  w_offset;
    logic [SCL_W-1:0]             w_scl;
    logic [T_W-1:0]               r_s2_t;
    logic [lorf_pkg::STATE_W-1:0] r_s2_mode;

    assign w_offset = 16'(17'(r_belief) + 17'(lorf_pkg::LO_LIMIT));
    assign w_scl    = SCL_W'(w_offset) * SCL_W'(SIGMOID_ENTRIES - 1)
                    + SCL_W'(lorf_pkg::LO_LIMIT);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_t    <= T_W'(w_scl >> lorf_pkg::LO_SPAN_SHIFT);
            r_s2_mode <= r_mode;
        end
    end

    // Stage 3: table index = floor(t / 5) by reciprocal multiplication.
    logic [DIVP_W-1:0]            w_div_prod;
    logic [IDX_W-1:0]             r_s3_idx;
    logic [lorf_pkg::STATE_W-1:0] r_s3_mode;

    assign w_div_prod = DIVP_W'(r_s2_t) * DIVP_W'(lorf_pkg::DIV5_MUL);

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_idx  <= w_div_prod[lorf_pkg::DIV5_SHIFT +: IDX_W];
            r_s3_mode <= r_s2_mode;
        end
    end

    // Sigmoid table, built at elaboration; entry i sits at the Q5.10 point
    // -20480 + floor(40960 * i / (N - 1)).
    logic [lorf_pkg::PROB_W-1:0] w_sig_rom [SIGMOID_ENTRIES];

    for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_sig
        localparam int X_PT = -lorf_pkg::LO_LIMIT
                            + (2 * lorf_pkg::LO_LIMIT * g) / (SIGMOID_ENTRIES - 1);
        localparam logic [lorf_pkg::PROB_W-1:0] SIG_VAL = lorf_pkg::sigmoid_q16(X_PT);
        assign w_sig_rom[g] = SIG_VAL;
    end

    // Stage 4: registered table read and output register.
    logic [lorf_pkg::PROB_W-1:0]  r_s4_prob;
    logic [lorf_pkg::STATE_W-1:0] r_s4_state;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_prob  <= w_sig_rom[r_s3_idx];
            r_s4_state <= r_s3_mode;
        end
    end

    assign o_risk.valid            = r_v4;
    assign o_risk.risk_state       = r_s4_state;
    assign o_risk.risk_probability = r_s4_prob;

endmodule

`default_nettype wire

[hw/rtl/lorf_checker.sv]
// ============================================================================
// Log-odds risk filter checker
// Port-level assertions on flow through the filter, bound to the top level.
// ============================================================================
`default_nettype none

module lorf_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [lorf_pkg::STATE_W-1:0]       i_out_state,
    input wire logic [lorf_pkg::PROB_W-1:0]        i_out_prob
);

    // A stalled result keeps its payload until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_state) && $stable(i_out_prob))
        else $error("result changed while stalled");

    // A ready receiver never back-pressures the frame channel.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("frame channel stalled while receiver ready");

    // With the receiver held ready, a frame transfer is followed by a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("result missing after pipeline latency");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind log_odds_risk_filter_top lorf_checker u_lorf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frame.valid),
    .i_in_ready  (i_frame.ready),
    .i_out_valid (o_risk.valid),
    .i_out_ready (o_risk.ready),
    .i_out_state (o_risk.risk_state),
    .i_out_prob  (o_risk.risk_probability)
);

`default_nettype wire
